// File: rtl/hpack_huffman_encoder_assert.svh
// ----------------------------------------------------------------------------
// hpack_huffman_encoder_assert
// Assertion macros for the HPACK Huffman encoder.
// ----------------------------------------------------------------------------
`ifndef HPACK_HUFFMAN_ENCODER_ASSERT_SVH
`define HPACK_HUFFMAN_ENCODER_ASSERT_SVH

// a condition implies another in the same cycle
`define HHE_ASSERT_IMP(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error(msg);

// a condition implies another in the next cycle
`define HHE_ASSERT_NEXT(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error(msg);

`endif

// File: rtl/hhe_pkg.sv
// ----------------------------------------------------------------------------
// hhe_pkg
// Types, constants and the static Huffman code table for the HPACK encoder.
// ----------------------------------------------------------------------------
package hhe_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int CODE_W = 30;
	localparam int LEN_W = 5;
	localparam int ACC_W = 37;
	localparam int NCNT_W = 6;
	localparam int TOT_W = 16;

	typedef struct packed {
		logic [7:0] symbol;
		logic       end_of_string;
	} in_word_t;

	typedef struct packed {
		logic [7:0]       code_byte;
		logic             final_byte;
		logic [TOT_W-1:0] total_bytes;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_PAD
	} state_t;

	// control from sequencer to datapath
	typedef struct packed {
		logic load;
		logic shift;
		logic pad;
		logic clear;
	} dp_ctrl_t;

	// status from datapath to sequencer
	typedef struct packed {
		logic full;
		logic more;
		logic partial;
		logic last;
	} dp_stat_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} code_ent_t;

	function automatic code_ent_t code_lookup(input logic [7:0] s);
		logic [31:0] c;
		logic [4:0]  l;
		begin
			c = 32'h0;
			l = 5'd0;
			case (s)
				8'd0: begin c = 32'h1ff8; l = 5'd13; end
				8'd1: begin c = 32'h7fffd8; l = 5'd23; end
				8'd2: begin c = 32'hfffffe2; l = 5'd28; end
				8'd3: begin c = 32'hfffffe3; l = 5'd28; end
				8'd4: begin c = 32'hfffffe4; l = 5'd28; end
				8'd5: begin c = 32'hfffffe5; l = 5'd28; end
				8'd6: begin c = 32'hfffffe6; l = 5'd28; end
				8'd7: begin c = 32'hfffffe7; l = 5'd28; end
				8'd8: begin c = 32'hfffffe8; l = 5'd28; end
				8'd9: begin c = 32'hffffea; l = 5'd24; end
				8'd10: begin c = 32'h3ffffffc; l = 5'd30; end
				8'd11: begin c = 32'hfffffe9; l = 5'd28; end
				8'd12: begin c = 32'hfffffea; l = 5'd28; end
				8'd13: begin c = 32'h3ffffffd; l = 5'd30; end
				8'd14: begin c = 32'hfffffeb; l = 5'd28; end
				8'd15: begin c = 32'hfffffec; l = 5'd28; end
				8'd16: begin c = 32'hfffffed; l = 5'd28; end
				8'd17: begin c = 32'hfffffee; l = 5'd28; end
				8'd18: begin c = 32'hfffffef; l = 5'd28; end
				8'd19: begin c = 32'hffffff0; l = 5'd28; end
				8'd20: begin c = 32'hffffff1; l = 5'd28; end
				8'd21: begin c = 32'hffffff2; l = 5'd28; end
				8'd22: begin c = 32'h3ffffffe; l = 5'd30; end
				8'd23: begin c = 32'hffffff3; l = 5'd28; end
				8'd24: begin c = 32'hffffff4; l = 5'd28; end
				8'd25: begin c = 32'hffffff5; l = 5'd28; end
				8'd26: begin c = 32'hffffff6; l = 5'd28; end
				8'd27: begin c = 32'hffffff7; l = 5'd28; end
				8'd28: begin c = 32'hffffff8; l = 5'd28; end
				8'd29: begin c = 32'hffffff9; l = 5'd28; end
				8'd30: begin c = 32'hffffffa; l = 5'd28; end
				8'd31: begin c = 32'hffffffb; l = 5'd28; end
				8'd32: begin c = 32'h14; l = 5'd6; end
				8'd33: begin c = 32'h3f8; l = 5'd10; end
				8'd34: begin c = 32'h3f9; l = 5'd10; end
				8'd35: begin c = 32'hffa; l = 5'd12; end
				8'd36: begin c = 32'h1ff9; l = 5'd13; end
				8'd37: begin c = 32'h15; l = 5'd6; end
				8'd38: begin c = 32'hf8; l = 5'd8; end
				8'd39: begin c = 32'h7fa; l = 5'd11; end
				8'd40: begin c = 32'h3fa; l = 5'd10; end
				8'd41: begin c = 32'h3fb; l = 5'd10; end
				8'd42: begin c = 32'hf9; l = 5'd8; end
				8'd43: begin c = 32'h7fb; l = 5'd11; end
				8'd44: begin c = 32'hfa; l = 5'd8; end
				8'd45: begin c = 32'h16; l = 5'd6; end
				8'd46: begin c = 32'h17; l = 5'd6; end
				8'd47: begin c = 32'h18; l = 5'd6; end
				8'd48: begin c = 32'h0; l = 5'd5; end
				8'd49: begin c = 32'h1; l = 5'd5; end
				8'd50: begin c = 32'h2; l = 5'd5; end
				8'd51: begin c = 32'h19; l = 5'd6; end
				8'd52: begin c = 32'h1a; l = 5'd6; end
				8'd53: begin c = 32'h1b; l = 5'd6; end
				8'd54: begin c = 32'h1c; l = 5'd6; end
				8'd55: begin c = 32'h1d; l = 5'd6; end
				8'd56: begin c = 32'h1e; l = 5'd6; end
				8'd57: begin c = 32'h1f; l = 5'd6; end
				8'd58: begin c = 32'h5c; l = 5'd7; end
				8'd59: begin c = 32'hfb; l = 5'd8; end
				8'd60: begin c = 32'h7ffc; l = 5'd15; end
				8'd61: begin c = 32'h20; l = 5'd6; end
				8'd62: begin c = 32'hffb; l = 5'd12; end
				8'd63: begin c = 32'h3fc; l = 5'd10; end
				8'd64: begin c = 32'h1ffa; l = 5'd13; end
				8'd65: begin c = 32'h21; l = 5'd6; end
				8'd66: begin c = 32'h5d; l = 5'd7; end
				8'd67: begin c = 32'h5e; l = 5'd7; end
				8'd68: begin c = 32'h5f; l = 5'd7; end
				8'd69: begin c = 32'h60; l = 5'd7; end
				8'd70: begin c = 32'h61; l = 5'd7; end
				8'd71: begin c = 32'h62; l = 5'd7; end
				8'd72: begin c = 32'h63; l = 5'd7; end
				8'd73: begin c = 32'h64; l = 5'd7; end
				8'd74: begin c = 32'h65; l = 5'd7; end
				8'd75: begin c = 32'h66; l = 5'd7; end
				8'd76: begin c = 32'h67; l = 5'd7; end
				8'd77: begin c = 32'h68; l = 5'd7; end
				8'd78: begin c = 32'h69; l = 5'd7; end
				8'd79: begin c = 32'h6a; l = 5'd7; end
				8'd80: begin c = 32'h6b; l = 5'd7; end
				8'd81: begin c = 32'h6c; l = 5'd7; end
				8'd82: begin c = 32'h6d; l = 5'd7; end
				8'd83: begin c = 32'h6e; l = 5'd7; end
				8'd84: begin c = 32'h6f; l = 5'd7; end
				8'd85: begin c = 32'h70; l = 5'd7; end
				8'd86: begin c = 32'h71; l = 5'd7; end
				8'd87: begin c = 32'h72; l = 5'd7; end
				8'd88: begin c = 32'hfc; l = 5'd8; end
				8'd89: begin c = 32'h73; l = 5'd7; end
				8'd90: begin c = 32'hfd; l = 5'd8; end
				8'd91: begin c = 32'h1ffb; l = 5'd13; end
				8'd92: begin c = 32'h7fff0; l = 5'd19; end
				8'd93: begin c = 32'h1ffc; l = 5'd13; end
				8'd94: begin c = 32'h3ffc; l = 5'd14; end
				8'd95: begin c = 32'h22; l = 5'd6; end
				8'd96: begin c = 32'h7ffd; l = 5'd15; end
				8'd97: begin c = 32'h3; l = 5'd5; end
				8'd98: begin c = 32'h23; l = 5'd6; end
				8'd99: begin c = 32'h4; l = 5'd5; end
				8'd100: begin c = 32'h24; l = 5'd6; end
				8'd101: begin c = 32'h5; l = 5'd5; end
				8'd102: begin c = 32'h25; l = 5'd6; end
				8'd103: begin c = 32'h26; l = 5'd6; end
				8'd104: begin c = 32'h27; l = 5'd6; end
				8'd105: begin c = 32'h6; l = 5'd5; end
				8'd106: begin c = 32'h74; l = 5'd7; end
				8'd107: begin c = 32'h75; l = 5'd7; end
				8'd108: begin c = 32'h28; l = 5'd6; end
				8'd109: begin c = 32'h29; l = 5'd6; end
				8'd110: begin c = 32'h2a; l = 5'd6; end
				8'd111: begin c = 32'h7; l = 5'd5; end
				8'd112: begin c = 32'h2b; l = 5'd6; end
				8'd113: begin c = 32'h76; l = 5'd7; end
				8'd114: begin c = 32'h2c; l = 5'd6; end
				8'd115: begin c = 32'h8; l = 5'd5; end
				8'd116: begin c = 32'h9; l = 5'd5; end
				8'd117: begin c = 32'h2d; l = 5'd6; end
				8'd118: begin c = 32'h77; l = 5'd7; end
				8'd119: begin c = 32'h78; l = 5'd7; end
				8'd120: begin c = 32'h79; l = 5'd7; end
				8'd121: begin c = 32'h7a; l = 5'd7; end
				8'd122: begin c = 32'h7b; l = 5'd7; end
				8'd123: begin c = 32'h7ffe; l = 5'd15; end
				8'd124: begin c = 32'h7fc; l = 5'd11; end
				8'd125: begin c = 32'h3ffd; l = 5'd14; end
				8'd126: begin c = 32'h1ffd; l = 5'd13; end
				8'd127: begin c = 32'hffffffc; l = 5'd28; end
				8'd128: begin c = 32'hfffe6; l = 5'd20; end
				8'd129: begin c = 32'h3fffd2; l = 5'd22; end
				8'd130: begin c = 32'hfffe7; l = 5'd20; end
				8'd131: begin c = 32'hfffe8; l = 5'd20; end
				8'd132: begin c = 32'h3fffd3; l = 5'd22; end
				8'd133: begin c = 32'h3fffd4; l = 5'd22; end
				8'd134: begin c = 32'h3fffd5; l = 5'd22; end
				8'd135: begin c = 32'h7fffd9; l = 5'd23; end
				8'd136: begin c = 32'h3fffd6; l = 5'd22; end
				8'd137: begin c = 32'h7fffda; l = 5'd23; end
				8'd138: begin c = 32'h7fffdb; l = 5'd23; end
				8'd139: begin c = 32'h7fffdc; l = 5'd23; end
				8'd140: begin c = 32'h7fffdd; l = 5'd23; end
				8'd141: begin c = 32'h7fffde; l = 5'd23; end
				8'd142: begin c = 32'hffffeb; l = 5'd24; end
				8'd143: begin c = 32'h7fffdf; l = 5'd23; end
				8'd144: begin c = 32'hffffec; l = 5'd24; end
				8'd145: begin c = 32'hffffed; l = 5'd24; end
				8'd146: begin c = 32'h3fffd7; l = 5'd22; end
				8'd147: begin c = 32'h7fffe0; l = 5'd23; end
				8'd148: begin c = 32'hffffee; l = 5'd24; end
				8'd149: begin c = 32'h7fffe1; l = 5'd23; end
				8'd150: begin c = 32'h7fffe2; l = 5'd23; end
				8'd151: begin c = 32'h7fffe3; l = 5'd23; end
				8'd152: begin c = 32'h7fffe4; l = 5'd23; end
				8'd153: begin c = 32'h1fffdc; l = 5'd21; end
				8'd154: begin c = 32'h3fffd8; l = 5'd22; end
				8'd155: begin c = 32'h7fffe5; l = 5'd23; end
				8'd156: begin c = 32'h3fffd9; l = 5'd22; end
				8'd157: begin c = 32'h7fffe6; l = 5'd23; end
				8'd158: begin c = 32'h7fffe7; l = 5'd23; end
				8'd159: begin c = 32'hffffef; l = 5'd24; end
				8'd160: begin c = 32'h3fffda; l = 5'd22; end
				8'd161: begin c = 32'h1fffdd; l = 5'd21; end
				8'd162: begin c = 32'hfffe9; l = 5'd20; end
				8'd163: begin c = 32'h3fffdb; l = 5'd22; end
				8'd164: begin c = 32'h3fffdc; l = 5'd22; end
				8'd165: begin c = 32'h7fffe8; l = 5'd23; end
				8'd166: begin c = 32'h7fffe9; l = 5'd23; end
				8'd167: begin c = 32'h1fffde; l = 5'd21; end
				8'd168: begin c = 32'h7fffea; l = 5'd23; end
				8'd169: begin c = 32'h3fffdd; l = 5'd22; end
				8'd170: begin c = 32'h3fffde; l = 5'd22; end
				8'd171: begin c = 32'hfffff0; l = 5'd24; end
				8'd172: begin c = 32'h1fffdf; l = 5'd21; end
				8'd173: begin c = 32'h3fffdf; l = 5'd22; end
				8'd174: begin c = 32'h7fffeb; l = 5'd23; end
				8'd175: begin c = 32'h7fffec; l = 5'd23; end
				8'd176: begin c = 32'h1fffe0; l = 5'd21; end
				8'd177: begin c = 32'h1fffe1; l = 5'd21; end
				8'd178: begin c = 32'h3fffe0; l = 5'd22; end
				8'd179: begin c = 32'h1fffe2; l = 5'd21; end
				8'd180: begin c = 32'h7fffed; l = 5'd23; end
				8'd181: begin c = 32'h3fffe1; l = 5'd22; end
				8'd182: begin c = 32'h7fffee; l = 5'd23; end
				8'd183: begin c = 32'h7fffef; l = 5'd23; end
				8'd184: begin c = 32'hfffea; l = 5'd20; end
				8'd185: begin c = 32'h3fffe2; l = 5'd22; end
				8'd186: begin c = 32'h3fffe3; l = 5'd22; end
				8'd187: begin c = 32'h3fffe4; l = 5'd22; end
				8'd188: begin c = 32'h7ffff0; l = 5'd23; end
				8'd189: begin c = 32'h3fffe5; l = 5'd22; end
				8'd190: begin c = 32'h3fffe6; l = 5'd22; end
				8'd191: begin c = 32'h7ffff1; l = 5'd23; end
				8'd192: begin c = 32'h3ffffe0; l = 5'd26; end
				8'd193: begin c = 32'h3ffffe1; l = 5'd26; end
				8'd194: begin c = 32'hfffeb; l = 5'd20; end
				8'd195: begin c = 32'h7fff1; l = 5'd19; end
				8'd196: begin c = 32'h3fffe7; l = 5'd22; end
				8'd197: begin c = 32'h7ffff2; l = 5'd23; end
				8'd198: begin c = 32'h3fffe8; l = 5'd22; end
				8'd199: begin c = 32'h1ffffec; l = 5'd25; end
				8'd200: begin c = 32'h3ffffe2; l = 5'd26; end
				8'd201: begin c = 32'h3ffffe3; l = 5'd26; end
				8'd202: begin c = 32'h3ffffe4; l = 5'd26; end
				8'd203: begin c = 32'h7ffffde; l = 5'd27; end
				8'd204: begin c = 32'h7ffffdf; l = 5'd27; end
				8'd205: begin c = 32'h3ffffe5; l = 5'd26; end
				8'd206: begin c = 32'hfffff1; l = 5'd24; end
				8'd207: begin c = 32'h1ffffed; l = 5'd25; end
				8'd208: begin c = 32'h7fff2; l = 5'd19; end
				8'd209: begin c = 32'h1fffe3; l = 5'd21; end
				8'd210: begin c = 32'h3ffffe6; l = 5'd26; end
				8'd211: begin c = 32'h7ffffe0; l = 5'd27; end
				8'd212: begin c = 32'h7ffffe1; l = 5'd27; end
				8'd213: begin c = 32'h3ffffe7; l = 5'd26; end
				8'd214: begin c = 32'h7ffffe2; l = 5'd27; end
				8'd215: begin c = 32'hfffff2; l = 5'd24; end
				8'd216: begin c = 32'h1fffe4; l = 5'd21; end
				8'd217: begin c = 32'h1fffe5; l = 5'd21; end
				8'd218: begin c = 32'h3ffffe8; l = 5'd26; end
				8'd219: begin c = 32'h3ffffe9; l = 5'd26; end
				8'd220: begin c = 32'hffffffd; l = 5'd28; end
				8'd221: begin c = 32'h7ffffe3; l = 5'd27; end
				8'd222: begin c = 32'h7ffffe4; l = 5'd27; end
				8'd223: begin c = 32'h7ffffe5; l = 5'd27; end
				8'd224: begin c = 32'hfffec; l = 5'd20; end
				8'd225: begin c = 32'hfffff3; l = 5'd24; end
				8'd226: begin c = 32'hfffed; l = 5'd20; end
				8'd227: begin c = 32'h1fffe6; l = 5'd21; end
				8'd228: begin c = 32'h3fffe9; l = 5'd22; end
				8'd229: begin c = 32'h1fffe7; l = 5'd21; end
				8'd230: begin c = 32'h1fffe8; l = 5'd21; end
				8'd231: begin c = 32'h7ffff3; l = 5'd23; end
				8'd232: begin c = 32'h3fffea; l = 5'd22; end
				8'd233: begin c = 32'h3fffeb; l = 5'd22; end
				8'd234: begin c = 32'h1ffffee; l = 5'd25; end
				8'd235: begin c = 32'h1ffffef; l = 5'd25; end
				8'd236: begin c = 32'hfffff4; l = 5'd24; end
				8'd237: begin c = 32'hfffff5; l = 5'd24; end
				8'd238: begin c = 32'h3ffffea; l = 5'd26; end
				8'd239: begin c = 32'h7ffff4; l = 5'd23; end
				8'd240: begin c = 32'h3ffffeb; l = 5'd26; end
				8'd241: begin c = 32'h7ffffe6; l = 5'd27; end
				8'd242: begin c = 32'h3ffffec; l = 5'd26; end
				8'd243: begin c = 32'h3ffffed; l = 5'd26; end
				8'd244: begin c = 32'h7ffffe7; l = 5'd27; end
				8'd245: begin c = 32'h7ffffe8; l = 5'd27; end
				8'd246: begin c = 32'h7ffffe9; l = 5'd27; end
				8'd247: begin c = 32'h7ffffea; l = 5'd27; end
				8'd248: begin c = 32'h7ffffeb; l = 5'd27; end
				8'd249: begin c = 32'hffffffe; l = 5'd28; end
				8'd250: begin c = 32'h7ffffec; l = 5'd27; end
				8'd251: begin c = 32'h7ffffed; l = 5'd27; end
				8'd252: begin c = 32'h7ffffee; l = 5'd27; end
				8'd253: begin c = 32'h7ffffef; l = 5'd27; end
				8'd254: begin c = 32'h7fffff0; l = 5'd27; end
				8'd255: begin c = 32'h3ffffee; l = 5'd26; end
				default: begin c = 32'h0; l = 5'd0; end
			endcase
			code_lookup.code = c[CODE_W-1:0];
			code_lookup.len  = l;
		end
	endfunction

endpackage

// File: rtl/hhe_datapath.sv
// ----------------------------------------------------------------------------
// hhe_datapath
// Bit accumulator with one shared byte extractor, leftover bits and byte count.
// ----------------------------------------------------------------------------
module hhe_datapath #(
	parameter int COUNT_WIDTH = hhe_pkg::COUNT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hhe_pkg::in_word_t   in_word,
	input  hhe_pkg::dp_ctrl_t   ctrl,
	output hhe_pkg::dp_stat_t   stat,
	output hhe_pkg::out_word_t  out_word
);
	import hhe_pkg::*;

	localparam int CNT_W = (COUNT_WIDTH > TOT_W) ? TOT_W : COUNT_WIDTH;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	code_ent_t          ent;
	logic [ACC_W-1:0]   acc_q;
	logic [NCNT_W-1:0]  n_q;
	logic [6:0]         pend_q;
	logic [2:0]         pcnt_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               last_q;
	logic [ACC_W-1:0]   acc_load;
	logic [NCNT_W-1:0]  n_sub;
	logic [7:0]         byte_sel;
	logic [7:0]         pad_byte;
	logic [7:0]         pad_mask;
	logic [CNT_W-1:0]   cnt_next;
	logic [NCNT_W-1:0]  n_rem;

	assign ent      = code_lookup(in_word.symbol);
	assign acc_load = ({30'd0, pend_q} << ent.len) | {7'd0, ent.code};
	assign n_sub    = n_q - NCNT_W'(8);
	// shared extractor: top byte of the live bits
	assign byte_sel = 8'(acc_q >> n_sub);
	assign pad_mask = 8'hff >> n_q[2:0];
	assign pad_byte = (8'(acc_q[6:0]) << (4'd8 - {1'b0, n_q[2:0]})) | pad_mask;
	assign cnt_next = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign n_rem    = ctrl.pad ? NCNT_W'(0) : n_sub;

	assign stat.full    = n_q >= NCNT_W'(8);
	assign stat.more    = n_sub >= NCNT_W'(8);
	assign stat.partial = n_q != '0;
	assign stat.last    = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			out_word <= '0;
			pend_q   <= '0;
			pcnt_q   <= '0;
			cnt_q    <= '0;
			n_q      <= '0;
			last_q   <= 1'b0;
		end else begin
			if (ctrl.load) begin
				acc_q  <= acc_load;
				n_q    <= NCNT_W'(pcnt_q) + NCNT_W'(ent.len);
				last_q <= in_word.end_of_string;
			end else if (ctrl.shift || ctrl.pad) begin
				out_word.code_byte   <= ctrl.pad ? pad_byte : byte_sel;
				out_word.final_byte  <= ctrl.pad ? 1'b1 : (last_q && n_sub == '0);
				out_word.total_bytes <= TOT_W'(cnt_next);
				cnt_q <= ctrl.clear ? '0 : cnt_next;
				n_q   <= n_rem;
			end else if (ctrl.clear) begin
				cnt_q <= '0;
			end
			if (ctrl.clear) begin
				pend_q <= '0;
				pcnt_q <= '0;
			end else if (ctrl.shift && !stat.more) begin
				pend_q <= acc_q[6:0] & ~(7'h7f << n_sub[2:0]);
				pcnt_q <= n_sub[2:0];
			end else if (ctrl.load && (NCNT_W'(pcnt_q) + NCNT_W'(ent.len)) < NCNT_W'(8)) begin
				pend_q <= acc_load[6:0];
				pcnt_q <= 3'(NCNT_W'(pcnt_q) + NCNT_W'(ent.len));
			end
		end
	end

endmodule

// File: rtl/hhe_seq.sv
// ----------------------------------------------------------------------------
// hhe_seq
// Sequencer: takes a word, emits one byte per handshake, pads at string end.
// ----------------------------------------------------------------------------
module hhe_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  hhe_pkg::dp_stat_t stat,
	output hhe_pkg::dp_ctrl_t ctrl
);
	import hhe_pkg::*;

	state_t state_q, state_d;
	logic   ov_q, ov_d;
	logic   slot;

	// output register free for a new byte
	assign slot = !ov_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q    <= ov_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		ov_d     = ov_q && !out_ready;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_d   = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// after the last whole byte the leftover bits decide pad or return
				if (stat.full) begin
					if (slot) begin
						ctrl.shift = 1'b1;
						ov_d       = 1'b1;
					end
				end else if (stat.last && stat.partial) begin
					state_d = ST_PAD;
				end else begin
					ctrl.clear = stat.last;
					state_d    = ST_IDLE;
				end
			end
			ST_PAD: begin
				if (slot) begin
					ctrl.pad   = 1'b1;
					ctrl.clear = 1'b1;
					ov_d       = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = ov_q;

endmodule

// File: rtl/hpack_huffman_encoder.sv
// ----------------------------------------------------------------------------
// hpack_huffman_encoder
// HPACK static Huffman encoder: one string byte in, zero to five code bytes out.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  in      | in_valid / in_ready   | in_word  (symbol, end_of_string)
//  out     | out_valid / out_ready | out_word (code_byte, final_byte, total_bytes)
//
// The code is accepted, looked up and loaded in ST_IDLE, each whole output
// byte is then taken from the shared byte extractor in ST_EMIT, and ST_EMIT
// then settles the leftover bits. At string end a pad byte, if any, is sent
// from ST_PAD. Output stalls hold the sequencer.
// Reset clears leftover bits, the byte count and the output valid.
module hpack_huffman_encoder #(
	parameter int COUNT_WIDTH = hhe_pkg::COUNT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hhe_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output hhe_pkg::out_word_t out_word
);
	import hhe_pkg::*;

	dp_ctrl_t ctrl;
	dp_stat_t stat;

	hhe_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	hhe_datapath #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (in_word),
		.ctrl     (ctrl),
		.stat     (stat),
		.out_word (out_word)
	);

`include "hpack_huffman_encoder_assert.svh"

	`HHE_ASSERT_IMP(a_load_idle, ctrl.load, in_ready && in_valid, "load outside accept")
	`HHE_ASSERT_NEXT(a_emit_valid, ctrl.shift || ctrl.pad, out_valid, "byte not presented")
	`HHE_ASSERT_IMP(a_one_op, ctrl.load, !ctrl.shift && !ctrl.pad, "load with emit")

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HPACK Huffman encoder: strings of random and
// directed bytes are fed in, the expected code bytes are worked out from the
// static table and every output word is compared in order.
// ----------------------------------------------------------------------------

class huff_scoreboard;
	hhe_pkg::out_word_t code_q[$];
	logic [6:0]  left_bits;
	int unsigned left_cnt;
	int unsigned str_bytes;
	int unsigned errors;
	int unsigned checked;
	int unsigned strings;

	function new();
		left_bits = '0;
		left_cnt = 0;
		str_bytes = 0;
		errors = 0;
		checked = 0;
		strings = 0;
	endfunction

	// static code table, RFC 7541 appendix B
	function automatic void huff_code(input logic [7:0] s, output logic [29:0] c,
			output int unsigned l);
		logic [31:0] tc [256];
		byte unsigned tl [256];
		tc = '{
		 'h1ff8,'h7fffd8,'hfffffe2,'hfffffe3,'hfffffe4,'hfffffe5,'hfffffe6,'hfffffe7,
		 'hfffffe8,'hffffea,'h3ffffffc,'hfffffe9,'hfffffea,'h3ffffffd,'hfffffeb,'hfffffec,
		 'hfffffed,'hfffffee,'hfffffef,'hffffff0,'hffffff1,'hffffff2,'h3ffffffe,'hffffff3,
		 'hffffff4,'hffffff5,'hffffff6,'hffffff7,'hffffff8,'hffffff9,'hffffffa,'hffffffb,
		 'h14,'h3f8,'h3f9,'hffa,'h1ff9,'h15,'hf8,'h7fa,
		 'h3fa,'h3fb,'hf9,'h7fb,'hfa,'h16,'h17,'h18,
		 'h0,'h1,'h2,'h19,'h1a,'h1b,'h1c,'h1d,
		 'h1e,'h1f,'h5c,'hfb,'h7ffc,'h20,'hffb,'h3fc,
		 'h1ffa,'h21,'h5d,'h5e,'h5f,'h60,'h61,'h62,
		 'h63,'h64,'h65,'h66,'h67,'h68,'h69,'h6a,
		 'h6b,'h6c,'h6d,'h6e,'h6f,'h70,'h71,'h72,
		 'hfc,'h73,'hfd,'h1ffb,'h7fff0,'h1ffc,'h3ffc,'h22,
		 'h7ffd,'h3,'h23,'h4,'h24,'h5,'h25,'h26,
		 'h27,'h6,'h74,'h75,'h28,'h29,'h2a,'h7,
		 'h2b,'h76,'h2c,'h8,'h9,'h2d,'h77,'h78,
		 'h79,'h7a,'h7b,'h7ffe,'h7fc,'h3ffd,'h1ffd,'hffffffc,
		 'hfffe6,'h3fffd2,'hfffe7,'hfffe8,'h3fffd3,'h3fffd4,'h3fffd5,'h7fffd9,
		 'h3fffd6,'h7fffda,'h7fffdb,'h7fffdc,'h7fffdd,'h7fffde,'hffffeb,'h7fffdf,
		 'hffffec,'hffffed,'h3fffd7,'h7fffe0,'hffffee,'h7fffe1,'h7fffe2,'h7fffe3,
		 'h7fffe4,'h1fffdc,'h3fffd8,'h7fffe5,'h3fffd9,'h7fffe6,'h7fffe7,'hffffef,
		 'h3fffda,'h1fffdd,'hfffe9,'h3fffdb,'h3fffdc,'h7fffe8,'h7fffe9,'h1fffde,
		 'h7fffea,'h3fffdd,'h3fffde,'hfffff0,'h1fffdf,'h3fffdf,'h7fffeb,'h7fffec,
		 'h1fffe0,'h1fffe1,'h3fffe0,'h1fffe2,'h7fffed,'h3fffe1,'h7fffee,'h7fffef,
		 'hfffea,'h3fffe2,'h3fffe3,'h3fffe4,'h7ffff0,'h3fffe5,'h3fffe6,'h7ffff1,
		 'h3ffffe0,'h3ffffe1,'hfffeb,'h7fff1,'h3fffe7,'h7ffff2,'h3fffe8,'h1ffffec,
		 'h3ffffe2,'h3ffffe3,'h3ffffe4,'h7ffffde,'h7ffffdf,'h3ffffe5,'hfffff1,'h1ffffed,
		 'h7fff2,'h1fffe3,'h3ffffe6,'h7ffffe0,'h7ffffe1,'h3ffffe7,'h7ffffe2,'hfffff2,
		 'h1fffe4,'h1fffe5,'h3ffffe8,'h3ffffe9,'hffffffd,'h7ffffe3,'h7ffffe4,'h7ffffe5,
		 'hfffec,'hfffff3,'hfffed,'h1fffe6,'h3fffe9,'h1fffe7,'h1fffe8,'h7ffff3,
		 'h3fffea,'h3fffeb,'h1ffffee,'h1ffffef,'hfffff4,'hfffff5,'h3ffffea,'h7ffff4,
		 'h3ffffeb,'h7ffffe6,'h3ffffec,'h3ffffed,'h7ffffe7,'h7ffffe8,'h7ffffe9,'h7ffffea,
		 'h7ffffeb,'hffffffe,'h7ffffec,'h7ffffed,'h7ffffee,'h7ffffef,'h7fffff0,'h3ffffee};
		tl = '{
		 13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
		 28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
		 6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
		 5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
		 13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
		 7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
		 15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
		 6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
		 20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
		 24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
		 22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
		 21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
		 26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
		 19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
		 20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
		 26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26};
		c = tc[s][29:0];
		l = tl[s];
	endfunction

	function void push_byte(input logic [7:0] b);
		hhe_pkg::out_word_t w;
		if (str_bytes < 16'hffff)
			str_bytes++;
		w.code_byte = b;
		w.final_byte = 1'b0;
		w.total_bytes = str_bytes[15:0];
		code_q.push_back(w);
	endfunction

	function void note_symbol(input hhe_pkg::in_word_t iw);
		logic [29:0] c;
		int unsigned l, n, k;
		logic [36:0] acc;
		huff_code(iw.symbol, c, l);
		n = left_cnt + l;
		acc = (37'(left_bits) << l) | 37'(c);
		k = 0;
		while (n >= 8) begin
			push_byte(8'(acc >> (n - 8)));
			k++;
			n -= 8;
		end
		left_bits = 7'(acc & ((37'd1 << n) - 1));
		left_cnt = n;
		if (iw.end_of_string) begin
			if (n > 0) begin
				// pad with ones, the EOS prefix
				push_byte(8'((left_bits << (8 - n)) | ((1 << (8 - n)) - 1)));
				k++;
			end
			if (k > 0)
				code_q[$].final_byte = 1'b1;
			left_bits = '0;
			left_cnt = 0;
			str_bytes = 0;
			strings++;
		end
	endfunction

	function void check_word(input hhe_pkg::out_word_t got);
		hhe_pkg::out_word_t exp;
		checked++;
		if (code_q.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected word: got %h/%b/%0d", got.code_byte,
					got.final_byte, got.total_bytes);
			return;
		end
		exp = code_q.pop_front();
		if (got.code_byte !== exp.code_byte || got.final_byte !== exp.final_byte ||
				got.total_bytes !== exp.total_bytes) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: exp %h/%b/%0d got %h/%b/%0d", exp.code_byte,
					exp.final_byte, exp.total_bytes, got.code_byte, got.final_byte,
					got.total_bytes);
		end
	endfunction
endclass

module tb;
	import hhe_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_word;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_word;

	huff_scoreboard sb;
	int  send_idle;
	int  recv_stall;
	bit  hold_off;
	int  n_sent;

	hpack_huffman_encoder DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
	);

	always begin
		clk = 1'b0; #2;
		clk = 1'b1; #2;
	end

	// one symbol, with random idle cycles first; valid stays up between words
	task automatic send_symbol(input logic [7:0] s, input logic eos);
		if (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= '{symbol: s, end_of_string: eos};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_symbol(in_word);
		n_sent++;
	endtask

	task automatic send_string(input int len, input int mode);
		logic [7:0] s;
		for (int i = 0; i < len; i++) begin
			case (mode)
				0: s = 8'($urandom_range(255));
				1: s = 8'($urandom_range(32, 126));
				default: s = 8'($urandom_range(128, 255));
			endcase
			send_symbol(s, i == len - 1);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.code_q.size() != 0)
			@(posedge clk);
	endtask

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				sb.check_word(out_word);
			out_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
		end
	end

	initial begin
		#4000000;
		$display("hpack_huffman_encoder test failed");
		$finish;
	end

	initial begin
		logic [7:0] dir_syms [$];
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		send_idle = 0;
		recv_stall = 0;
		hold_off = 0;
		n_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: shortest and longest codes, single-symbol strings, an aligned end
		send_symbol(8'd48, 1'b1);
		send_symbol(8'd10, 1'b1);
		send_symbol(8'd38, 1'b1);
		send_symbol(8'd0, 1'b1);
		send_symbol(8'd255, 1'b1);
		dir_syms = '{8'd13, 8'd22, 8'd10, 8'd13, 8'd97, 8'd101, 8'd105, 8'd111, 8'd49,
			8'd127, 8'd128, 8'd92};
		foreach (dir_syms[i])
			send_symbol(dir_syms[i], i == dir_syms.size() - 1);
		// 8-bit codes back to back end exactly aligned
		send_symbol(8'd42, 1'b0);
		send_symbol(8'd44, 1'b0);
		send_symbol(8'd59, 1'b1);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 70; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 70; end
				default: begin send_idle = 20; recv_stall = 20; end
			endcase
			for (int k = 0; k < 12; k++)
				send_string($urandom_range(1, 7), $urandom_range(2));
			if (ph == 1) begin
				// sender waits until everything is out
				drain();
			end
		end

		// long receiver hold-off while input keeps coming
		send_idle = 0;
		recv_stall = 0;
		hold_off = 1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			send_string(20, 2);
		join

		// one long string exercising the byte count
		send_string(40, 0);
		drain();
		repeat (20) @(posedge clk);

		$display("sent %0d symbols in %0d strings, checked %0d code bytes",
			n_sent, sb.strings, sb.checked);
		if (sb.errors == 0 && sb.code_q.size() == 0)
			$display("hpack_huffman_encoder test passed");
		else
			$display("hpack_huffman_encoder test failed");
		$finish;
	end
endmodule
